// File: hw/rtl/kmll_pkg.sv
// Shared constants and codes for the k-means refinement block.
`timescale 1ns / 1ps
package kmll_pkg;
   localparam int MAX_SAMPLES  = 256;
   localparam int MAX_DIMS     = 8;
   localparam int MAX_CLUSTERS = 8;
   localparam int COORD_BITS   = 16;

   localparam int SIDX_W  = 8;               // sample index
   localparam int DIDX_W  = 3;               // dimension index
   localparam int CIDX_W  = 3;               // cluster index
   localparam int SADDR_W = SIDX_W + DIDX_W;
   localparam int CADDR_W = CIDX_W + DIDX_W;
   localparam int LQ_W    = 12;              // sample load quotient
   localparam int CQ_W    = 7;               // centre load quotient
   localparam int SCNT_W  = 9;               // sample count / member count
   localparam int SUM_W   = 25;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int SQ_W    = 32;
   localparam int DIST_W  = 35;
   localparam int COST_W  = 48;
   localparam int DIV_W   = 25;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_CENTER = 2'd1;
   localparam logic [1:0] REQ_START  = 2'd2;

   localparam logic [1:0] CAUSE_CONV  = 2'd0;
   localparam logic [1:0] CAUSE_EMPTY = 2'd1;
   localparam logic [1:0] CAUSE_LIMIT = 2'd2;

   localparam logic [1:0] REG_CLUSTERS = 2'd0;
   localparam logic [1:0] REG_DIMS     = 2'd1;
   localparam logic [1:0] REG_LIMIT    = 2'd2;

   typedef logic [COORD_BITS-1:0] coord_type;
endpackage

// File: hw/rtl/kmll_div.sv
// Restoring divider, one quotient bit a cycle, for the rounded centre means.
`timescale 1ns / 1ps
module kmll_div import kmll_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [SCNT_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [SCNT_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [SCNT_W:0]   trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      ge      = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? SCNT_W'(trial - {1'b0, divisor}) : trial[SCNT_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: hw/rtl/kmeans_lloyd_refinement_top.sv
// Lloyd k-means refinement block: loaders, pass sequencer, stores and result port.
//
// Request channel (req_valid / req_stall): sample coordinates and initial centre
// coordinates are loaded one per cycle while req_stall is low, vector by vector;
// first_of_set restarts the addressed set at entry zero. A start request runs
// refinement. Loads and unknown requests give no response. req_stall is high
// from the start request until the last centre coordinate has been taken.
// Response channel (rsp_valid / rsp_stall): one response per centre
// coordinate, cluster-major, last_result on the final one. A stalled
// response holds until taken; the block waits meanwhile.
// Each pass runs, per sample and cluster, the distance step through the
// states DRD, DDIF, DSQ and DACC on the single read ports of the sample and
// centre stores, then one-bit-a-cycle division for each new centre coordinate;
// the final cost sweep reruns the distance step for each sample's assigned
// cluster, and each response goes through states OUT_RD, OUT_LD and OUT_WAIT.
// Reset (synchronous) empties the sample set, rewinds both loaders and sets
// the registers to 2 clusters, 2 dimensions and 100 passes; stores hold
// whatever they held and need loading before use.
`timescale 1ns / 1ps
module kmeans_lloyd_refinement_top import kmll_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic signed [15:0]    req_coordinate,
   input  logic                  req_first_of_set,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_cluster_index,
   output logic [2:0]            rsp_dimension_index,
   output logic signed [15:0]    rsp_center_coordinate,
   output logic [7:0]            rsp_passes_done,
   output logic [1:0]            rsp_stop_cause,
   output logic [47:0]           rsp_total_cost,
   output logic                  rsp_last_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_PASS_CHK = 5'd1;
   localparam logic [4:0] ST_SAMPLE   = 5'd2;
   localparam logic [4:0] ST_DRD      = 5'd3;
   localparam logic [4:0] ST_DDIF     = 5'd4;
   localparam logic [4:0] ST_DSQ      = 5'd5;
   localparam logic [4:0] ST_DACC     = 5'd6;
   localparam logic [4:0] ST_ASG_RD   = 5'd7;
   localparam logic [4:0] ST_ASG_UPD  = 5'd8;
   localparam logic [4:0] ST_SUM_RD   = 5'd9;
   localparam logic [4:0] ST_SUM_WR   = 5'd10;
   localparam logic [4:0] ST_PEND     = 5'd11;
   localparam logic [4:0] ST_UPD_RD   = 5'd12;
   localparam logic [4:0] ST_UPD_DIV  = 5'd13;
   localparam logic [4:0] ST_UPD_WAIT = 5'd14;
   localparam logic [4:0] ST_COST     = 5'd15;
   localparam logic [4:0] ST_COST_S   = 5'd16;
   localparam logic [4:0] ST_COST_A   = 5'd17;
   localparam logic [4:0] ST_OUT_RD   = 5'd18;
   localparam logic [4:0] ST_OUT_LD   = 5'd19;
   localparam logic [4:0] ST_OUT_WAIT = 5'd20;

   // ---------------- configuration registers
   logic [3:0] kreg_ff, dreg_ff;
   logic [7:0] lim_ff;
   logic [2:0] kl, dl;     // last cluster / last dimension in use
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kreg_ff <= 4'd2;
         dreg_ff <= 4'd2;
         lim_ff  <= 8'd100;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_CLUSTERS: kreg_ff <= pwdata[3:0];
            REG_DIMS:     dreg_ff <= pwdata[3:0];
            REG_LIMIT:    lim_ff  <= pwdata[7:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_CLUSTERS: prdata = {28'd0, kreg_ff};
         REG_DIMS:     prdata = {28'd0, dreg_ff};
         REG_LIMIT:    prdata = {24'd0, lim_ff};
         default:      prdata = '0;
      endcase
   end

   // zero acts as one, above the maximum acts as the maximum
   assign kl = (kreg_ff == 4'd0) ? 3'd0 :
               (kreg_ff > 4'(MAX_CLUSTERS)) ? 3'(MAX_CLUSTERS - 1) : 3'(kreg_ff - 4'd1);
   assign dl = (dreg_ff == 4'd0) ? 3'd0 :
               (dreg_ff > 4'(MAX_DIMS)) ? 3'(MAX_DIMS - 1) : 3'(dreg_ff - 4'd1);

   // ---------------- state
   logic [4:0]        state_ff, state_in;
   logic [LQ_W-1:0]   lq_ff [MAX_DIMS];
   logic [LQ_W-1:0]   lq_in [MAX_DIMS];
   logic [2:0]        lr_ff [MAX_DIMS];
   logic [2:0]        lr_in [MAX_DIMS];
   logic [CQ_W-1:0]   cq_ff [MAX_DIMS];
   logic [CQ_W-1:0]   cq_in [MAX_DIMS];
   logic [2:0]        cr_ff [MAX_DIMS];
   logic [2:0]        cr_in [MAX_DIMS];
   logic [SCNT_W-1:0] scount_ff, scount_in;
   logic [SCNT_W-1:0] s_ff, s_in;
   logic [CIDX_W-1:0] c_ff, c_in;
   logic [DIDX_W-1:0] d_ff, d_in;
   logic [DIST_W-1:0] acc_ff, acc_in, bestd_ff, bestd_in, acc_sum;
   logic [CIDX_W-1:0] best_ff, best_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic              changed_ff, changed_in, costm_ff, costm_in, neg_ff, neg_in;
   logic [7:0]        passes_ff, passes_in;
   logic [1:0]        cause_ff, cause_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [SCNT_W-1:0] cnt_ff [MAX_CLUSTERS];
   logic [SCNT_W-1:0] cnt_in [MAX_CLUSTERS];
   logic [MAX_CLUSTERS*MAX_DIMS-1:0] svld_ff, svld_in;

   logic              rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [2:0]        rclu_ff, rclu_in, rdim_ff, rdim_in;
   coord_type         rcoord_ff, rcoord_in;

   // memories
   coord_type         smem [MAX_SAMPLES*MAX_DIMS];
   coord_type         cmem [MAX_CLUSTERS*MAX_DIMS];
   logic [SUM_W-1:0]  summem [MAX_CLUSTERS*MAX_DIMS];
   logic [CIDX_W-1:0] amem [MAX_SAMPLES];
   coord_type         s_rd, c_rd;
   logic [SUM_W-1:0]  sum_rd;
   logic [CIDX_W-1:0] a_rd;

   logic              s_we, c_we, sum_we, a_we;
   logic [SADDR_W-1:0] s_waddr, s_raddr;
   logic [CADDR_W-1:0] c_waddr, cd_addr;
   coord_type         s_wdata, c_wdata;
   logic [SUM_W-1:0]  sum_wdata;

   // divider
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_num, div_q;
   logic [SUM_W-2:0]  sum_mag;
   coord_type         mean_val;

   kmll_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (cnt_ff[c_ff]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign s_raddr = {s_ff[SIDX_W-1:0], d_ff};
   assign cd_addr = {c_ff, d_ff};

   always_ff @(posedge clock) begin
      if (s_we) smem[s_waddr] <= s_wdata;
      s_rd <= smem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) cmem[c_waddr] <= c_wdata;
      c_rd <= cmem[cd_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) summem[cd_addr] <= sum_wdata;
      sum_rd <= summem[cd_addr];
   end

   always_ff @(posedge clock) begin
      if (a_we) amem[s_ff[SIDX_W-1:0]] <= best_ff;
      a_rd <= amem[s_ff[SIDX_W-1:0]];
   end

   // ---------------- next state
   logic              req_acc, is_load_s, is_load_c;
   logic [LQ_W-1:0]   lbase_q [MAX_DIMS];
   logic [2:0]        lbase_r [MAX_DIMS];
   logic [CQ_W-1:0]   cbase_q [MAX_DIMS];
   logic [2:0]        cbase_r [MAX_DIMS];
   logic              lok, cok, empty;
   logic [SUM_W-1:0]  sum_old;

   assign req_acc   = req_valid & ~req_stall;
   assign is_load_s = req_acc && (req_type == REQ_SAMPLE);
   assign is_load_c = req_acc && (req_type == REQ_CENTER);
   assign req_stall = (state_ff != ST_IDLE);

   assign sum_mag = sum_rd[SUM_W-1] ? (SUM_W-1)'(-sum_rd) : sum_rd[SUM_W-2:0];
   assign div_num = DIV_W'(sum_mag) + DIV_W'(cnt_ff[c_ff] >> 1);
   assign mean_val = neg_ff ? coord_type'(-div_q[COORD_BITS-1:0]) : div_q[COORD_BITS-1:0];
   assign sum_old = svld_ff[cd_addr] ? sum_rd : '0;
   assign acc_sum = acc_ff + DIST_W'(sq_ff);

   always_comb begin
      state_in   = state_ff;
      scount_in  = scount_ff;
      s_in       = s_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      acc_in     = acc_ff;
      bestd_in   = bestd_ff;
      best_in    = best_ff;
      diff_in    = diff_ff;
      sq_in      = sq_ff;
      changed_in = changed_ff;
      costm_in   = costm_ff;
      neg_in     = neg_ff;
      passes_in  = passes_ff;
      cause_in   = cause_ff;
      cost_in    = cost_ff;
      svld_in    = svld_ff;
      rvalid_in  = rvalid_ff;
      rlast_in   = rlast_ff;
      rclu_in    = rclu_ff;
      rdim_in    = rdim_ff;
      rcoord_in  = rcoord_ff;
      s_we       = 1'b0;
      c_we       = 1'b0;
      sum_we     = 1'b0;
      a_we       = 1'b0;
      div_start  = 1'b0;
      sum_wdata  = sum_old + SUM_W'(signed'(s_rd));
      empty      = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         lbase_q[i] = req_first_of_set ? '0 : lq_ff[i];
         lbase_r[i] = req_first_of_set ? '0 : lr_ff[i];
         cbase_q[i] = req_first_of_set ? '0 : cq_ff[i];
         cbase_r[i] = req_first_of_set ? '0 : cr_ff[i];
         lq_in[i]   = lq_ff[i];
         lr_in[i]   = lr_ff[i];
         cq_in[i]   = cq_ff[i];
         cr_in[i]   = cr_ff[i];
      end
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (3'(i) <= kl && cnt_ff[i] == '0) empty = 1'b1;
      end
      lok = lbase_q[dl] < LQ_W'(MAX_SAMPLES);
      cok = cbase_q[dl] < CQ_W'(MAX_CLUSTERS);

      // loader address and write mux
      s_waddr = {lbase_q[dl][SIDX_W-1:0], lbase_r[dl]};
      s_wdata = req_coordinate;
      c_waddr = {cbase_q[dl][CIDX_W-1:0], cbase_r[dl]};
      c_wdata = req_coordinate;

      // one quotient/remainder counter pair per possible dimension count
      if (is_load_s) begin
         if (lok) begin
            s_we = 1'b1;
            for (int i = 0; i < MAX_DIMS; i++) begin
               if (lbase_r[i] == 3'(i)) begin
                  lq_in[i] = lbase_q[i] + 1'b1;
                  lr_in[i] = '0;
               end else begin
                  lq_in[i] = lbase_q[i];
                  lr_in[i] = lbase_r[i] + 3'd1;
               end
            end
            scount_in = (lbase_r[dl] == dl) ? SCNT_W'(lbase_q[dl] + 1'b1)
                                            : SCNT_W'(lbase_q[dl]);
         end
      end
      if (is_load_c) begin
         if (cok) begin
            c_we = 1'b1;
            for (int i = 0; i < MAX_DIMS; i++) begin
               if (cbase_r[i] == 3'(i)) begin
                  cq_in[i] = cbase_q[i] + 1'b1;
                  cr_in[i] = '0;
               end else begin
                  cq_in[i] = cbase_q[i];
                  cr_in[i] = cbase_r[i] + 3'd1;
               end
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_type == REQ_START) begin
               passes_in = '0;
               state_in  = ST_PASS_CHK;
            end
         end
         ST_PASS_CHK: begin
            if (passes_ff < lim_ff) begin
               passes_in  = passes_ff + 8'd1;
               changed_in = 1'b0;
               costm_in   = 1'b0;
               svld_in    = '0;
               s_in       = '0;
               for (int i = 0; i < MAX_CLUSTERS; i++) cnt_in[i] = '0;
               state_in   = ST_SAMPLE;
            end else begin
               cause_in = CAUSE_LIMIT;
               state_in = ST_COST;
            end
         end
         ST_SAMPLE: begin
            if (s_ff == scount_ff) begin
               state_in = ST_PEND;
            end else begin
               c_in     = '0;
               d_in     = '0;
               acc_in   = '0;
               state_in = ST_DRD;
            end
         end
         ST_DRD: state_in = ST_DDIF;
         ST_DDIF: begin
            diff_in  = DIFF_W'(signed'(s_rd)) - DIFF_W'(signed'(c_rd));
            state_in = ST_DSQ;
         end
         ST_DSQ: begin
            sq_in    = SQ_W'(diff_ff * diff_ff);
            state_in = ST_DACC;
         end
         ST_DACC: begin
            if (d_ff != dl) begin
               d_in     = d_ff + 3'd1;
               acc_in   = acc_sum;
               state_in = ST_DRD;
            end else if (costm_ff) begin
               cost_in  = cost_ff + COST_W'(acc_sum);
               s_in     = s_ff + 1'b1;
               state_in = ST_COST_S;
            end else begin
               // lowest index wins a tie
               if (c_ff == '0 || acc_sum < bestd_ff) begin
                  best_in  = c_ff;
                  bestd_in = acc_sum;
               end
               if (c_ff == kl) begin
                  state_in = ST_ASG_RD;
               end else begin
                  c_in     = c_ff + 3'd1;
                  d_in     = '0;
                  acc_in   = '0;
                  state_in = ST_DRD;
               end
            end
         end
         ST_ASG_RD: state_in = ST_ASG_UPD;
         ST_ASG_UPD: begin
            // before the first pass every sample sits in cluster zero
            if (best_ff != ((passes_ff == 8'd1) ? '0 : a_rd)) changed_in = 1'b1;
            a_we     = 1'b1;
            c_in     = best_ff;
            d_in     = '0;
            state_in = ST_SUM_RD;
         end
         ST_SUM_RD: state_in = ST_SUM_WR;
         ST_SUM_WR: begin
            sum_we           = 1'b1;
            svld_in[cd_addr] = 1'b1;
            if (d_ff == dl) begin
               cnt_in[c_ff] = cnt_ff[c_ff] + 1'b1;
               s_in         = s_ff + 1'b1;
               state_in     = ST_SAMPLE;
            end else begin
               d_in     = d_ff + 3'd1;
               state_in = ST_SUM_RD;
            end
         end
         ST_PEND: begin
            if (empty) begin
               cause_in = CAUSE_EMPTY;
               state_in = ST_COST;
            end else if (!changed_ff) begin
               cause_in = CAUSE_CONV;
               state_in = ST_COST;
            end else begin
               c_in     = '0;
               d_in     = '0;
               state_in = ST_UPD_RD;
            end
         end
         ST_UPD_RD: state_in = ST_UPD_DIV;
         ST_UPD_DIV: begin
            div_start = 1'b1;
            neg_in    = sum_rd[SUM_W-1];
            state_in  = ST_UPD_WAIT;
         end
         ST_UPD_WAIT: begin
            if (div_done) begin
               c_we    = 1'b1;
               c_waddr = cd_addr;
               c_wdata = mean_val;
               if (d_ff != dl) begin
                  d_in     = d_ff + 3'd1;
                  state_in = ST_UPD_RD;
               end else if (c_ff != kl) begin
                  c_in     = c_ff + 3'd1;
                  d_in     = '0;
                  state_in = ST_UPD_RD;
               end else begin
                  cause_in = CAUSE_LIMIT;
                  state_in = ST_PASS_CHK;
               end
            end
         end
         ST_COST: begin
            s_in     = '0;
            cost_in  = '0;
            costm_in = 1'b1;
            state_in = ST_COST_S;
         end
         ST_COST_S: begin
            if (s_ff == scount_ff) begin
               c_in     = '0;
               d_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_COST_A;
            end
         end
         ST_COST_A: begin
            c_in     = (passes_ff == 8'd0) ? '0 : a_rd;
            d_in     = '0;
            acc_in   = '0;
            state_in = ST_DRD;
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            rvalid_in = 1'b1;
            rclu_in   = c_ff;
            rdim_in   = d_ff;
            rcoord_in = c_rd;
            rlast_in  = (c_ff == kl) && (d_ff == dl);
            state_in  = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rvalid_in = 1'b0;
               if (rlast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  if (d_ff == dl) begin
                     c_in = c_ff + 3'd1;
                     d_in = '0;
                  end else begin
                     d_in = d_ff + 3'd1;
                  end
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scount_ff <= '0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            lq_ff[i] <= '0;
            lr_ff[i] <= '0;
            cq_ff[i] <= '0;
            cr_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         scount_ff <= scount_in;
         rvalid_ff <= rvalid_in;
         for (int i = 0; i < MAX_DIMS; i++) begin
            lq_ff[i] <= lq_in[i];
            lr_ff[i] <= lr_in[i];
            cq_ff[i] <= cq_in[i];
            cr_ff[i] <= cr_in[i];
         end
      end
      s_ff       <= s_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      acc_ff     <= acc_in;
      bestd_ff   <= bestd_in;
      best_ff    <= best_in;
      diff_ff    <= diff_in;
      sq_ff      <= sq_in;
      changed_ff <= changed_in;
      costm_ff   <= costm_in;
      neg_ff     <= neg_in;
      passes_ff  <= passes_in;
      cause_ff   <= cause_in;
      cost_ff    <= cost_in;
      svld_ff    <= svld_in;
      rlast_ff   <= rlast_in;
      rclu_ff    <= rclu_in;
      rdim_ff    <= rdim_in;
      rcoord_ff  <= rcoord_in;
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt_ff[i] <= cnt_in[i];
   end

   assign rsp_valid             = rvalid_ff;
   assign rsp_cluster_index     = rclu_ff;
   assign rsp_dimension_index   = rdim_ff;
   assign rsp_center_coordinate = rcoord_ff;
   assign rsp_passes_done       = passes_ff;
   assign rsp_stop_cause        = cause_ff;
   assign rsp_total_cost        = cost_ff;
   assign rsp_last_result       = rlast_ff;
endmodule
